@@ rtl/lfcd_pkg.sv @@
package lfcd_pkg;

    localparam int SLOTS_DEF  = 8;
    localparam int FRAME_W    = 47;
    localparam int INDEX_W    = 48;
    localparam int STAMP_W    = 64;
    localparam int SLOT_IDX_W = 8;
    localparam int OUT_SLOT_W = 3;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_ABORT   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // search token passed from cell to cell
    typedef struct packed {
        logic                  pvalid;
        logic                  found;
        logic [SLOT_IDX_W-1:0] hit_slot;
        logic                  have_empty;
        logic [SLOT_IDX_W-1:0] empty_slot;
        logic                  best_set;
        logic [SLOT_IDX_W-1:0] best_slot;
        logic [STAMP_W-1:0]    best_stamp;
    } probe_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic                  stamp_en;
        logic                  fill;
        logic                  inval;
        logic [SLOT_IDX_W-1:0] slot;
        logic [FRAME_W-1:0]    tag;
        logic [STAMP_W-1:0]    stamp;
    } upd_t;

endpackage

@@ rtl/lfcd_cell.sv @@
module lfcd_cell
    import lfcd_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FRAME_W-1:0] key,
    input  probe_t             probe_in,
    output probe_t             probe_out,
    input  upd_t               upd,
    output logic               valid
);

    localparam logic [SLOT_IDX_W-1:0] MY_SLOT = SLOT_IDX_W'(IDX);

    logic               valid_reg;
    logic               valid_next;
    logic [FRAME_W-1:0] tag_reg;
    logic [FRAME_W-1:0] tag_next;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] stamp_next;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic               sel;

    assign sel = (upd.slot == MY_SLOT);

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.found && valid_reg && (tag_reg == key))
        begin
            probe_next.found    = 1'b1;
            probe_next.hit_slot = MY_SLOT;
        end
        if (!probe_in.have_empty && !valid_reg)
        begin
            probe_next.have_empty = 1'b1;
            probe_next.empty_slot = MY_SLOT;
        end
        // strict compare keeps the lowest slot on equal stamps
        if (!probe_in.best_set || (stamp_reg < probe_in.best_stamp))
        begin
            probe_next.best_set   = 1'b1;
            probe_next.best_slot  = MY_SLOT;
            probe_next.best_stamp = stamp_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        stamp_next = stamp_reg;
        if (sel && upd.stamp_en)
        begin
            stamp_next = upd.stamp;
        end
        if (sel && upd.fill)
        begin
            valid_next = 1'b1;
            tag_next   = upd.tag;
        end
        if (sel && upd.inval)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
            probe_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            stamp_reg <= stamp_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign probe_out = probe_reg;
    assign valid     = valid_reg;

endmodule

@@ rtl/lru_frame_cache_directory.sv @@
// tag directory of a fully associative frame cache, least-recently-used replacement
// input channel (in_valid/in_ready): cmd, frame_no, abort_slot
//   request: frame_no is clamped into 0..num_frames-1 and looked up
//   abort: abort_slot is marked empty, result echoes the slot
// output channel (out_valid/out_ready): hit, slot_number, served_index
// user writes num_frames via num_frames_wr only while idle; block does not enforce
// a request launches a search token after accept; the token walks the row of
//   slot cells one cell per cycle, then a register picks hit, first empty or
//   oldest slot, and the update step writes it back and loads the result;
//   the input is ready again only after the update step, so a new request is
//   not taken before the last one is through
// an abort goes straight to the update step; one item is in the block at a time
// the result sits in an output register, so the next item is taken while it
// waits; if the receiver stalls, the following item holds in its write-back
// step until the output register is free
// reset empties every slot, clears stamps and the use clock, num_frames = 1
module lru_frame_cache_directory
    import lfcd_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  num_frames_wr,
    input  logic [FRAME_W-1:0]    num_frames,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [INDEX_W-1:0]    frame_no,
    input  logic [OUT_SLOT_W-1:0] abort_slot,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  hit,
    output logic [OUT_SLOT_W-1:0] slot_number,
    output logic [FRAME_W-1:0]    served_index
);

    state_t state_reg;
    state_t state_next;

    logic [FRAME_W-1:0]    fc_max_reg;
    logic [FRAME_W-1:0]    served_reg;
    logic [FRAME_W-1:0]    served_next;
    logic                  cmd_reg;
    logic [OUT_SLOT_W-1:0] abort_reg;
    logic                  launch_reg;
    logic                  dec_hit_reg;
    logic [SLOT_IDX_W-1:0] dec_slot_reg;
    logic [STAMP_W-1:0]    use_clock_reg;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [OUT_SLOT_W-1:0] slot_number_reg;
    logic [FRAME_W-1:0]    served_index_reg;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  scan_done;
    upd_t                  upd;
    probe_t                probe_w [SLOTS+1];
    logic [SLOTS-1:0]      valid_vec;
    logic [SLOTS-1:0]      pvalid_vec;
    probe_t                last;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last      = probe_w[SLOTS];
    assign scan_done = last.pvalid;

    // clamp: negative to zero, too large to the last frame
    always_comb
    begin
        if (frame_no[INDEX_W-1])
        begin
            served_next = '0;
        end
        else if (frame_no[FRAME_W-1:0] > fc_max_reg)
        begin
            served_next = fc_max_reg;
        end
        else
        begin
            served_next = frame_no[FRAME_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == CMD_ABORT) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        upd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
            end
            ST_UPDATE:
            begin
                out_load = out_free;
                upd.tag  = served_reg;
                upd.stamp = use_clock_reg + STAMP_W'(1);
                if (cmd_reg == CMD_ABORT)
                begin
                    upd.inval = out_free;
                    upd.slot  = SLOT_IDX_W'(abort_reg);
                end
                else
                begin
                    upd.stamp_en = out_free;
                    upd.fill     = out_free && !dec_hit_reg;
                    upd.slot     = dec_slot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign probe_w[0] = '{pvalid: launch_reg, default: '0};

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        lfcd_cell #(
            .IDX(i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (served_reg),
            .probe_in (probe_w[i]),
            .probe_out(probe_w[i+1]),
            .upd      (upd),
            .valid    (valid_vec[i])
        );
        assign pvalid_vec[i] = probe_w[i+1].pvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fc_max_reg    <= '0;
            launch_reg    <= 1'b0;
            use_clock_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept && (cmd == CMD_REQUEST);
            if (num_frames_wr)
            begin
                // zero frames behaves as one
                fc_max_reg <= (num_frames == '0) ? '0 : num_frames - FRAME_W'(1);
            end
            if (upd.stamp_en)
            begin
                use_clock_reg <= upd.stamp;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            served_reg <= served_next;
            abort_reg  <= abort_slot;
        end
        if (scan_done)
        begin
            dec_hit_reg <= last.found;
            if (last.found)
            begin
                dec_slot_reg <= last.hit_slot;
            end
            else if (last.have_empty)
            begin
                dec_slot_reg <= last.empty_slot;
            end
            else
            begin
                dec_slot_reg <= last.best_slot;
            end
        end
        if (out_load)
        begin
            if (cmd_reg == CMD_ABORT)
            begin
                hit_reg          <= 1'b0;
                slot_number_reg  <= abort_reg;
                served_index_reg <= '0;
            end
            else
            begin
                hit_reg          <= dec_hit_reg;
                slot_number_reg  <= dec_slot_reg[OUT_SLOT_W-1:0];
                served_index_reg <= served_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign slot_number  = slot_number_reg;
    assign served_index = served_index_reg;

`ifndef ASSERT_OFF
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({pvalid_vec, launch_reg}))
        else $error("more than one search token in the cell row");

    a_probe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == ST_SCAN))
        else $error("search token finished outside the scan step");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (upd.stamp_en && dec_hit_reg) |-> |(valid_vec & (SLOTS'(1) << dec_slot_reg)))
        else $error("hit reported on an empty slot");

    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd.stamp_en |=> (use_clock_reg == $past(use_clock_reg) + STAMP_W'(1)))
        else $error("use clock did not advance by one");

    a_fill_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        upd.fill |=> |(valid_vec & (SLOTS'(1) << $past(upd.slot))))
        else $error("filled slot not marked valid");
`endif

endmodule
